[hw/rtl/scar_pkg.sv]
// ============================================================================
// scar_pkg: shared types, constants and helpers for the stereo reverb
// Item and configuration types, the tuning tables and the saturating and
// rounding helpers used by the front and back parts of the block.
// ============================================================================
package scar_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int ACC_W       = 48;
    localparam int CFG_W       = 17;
    localparam int NCOMB       = 4;
    localparam int NAP         = 2;
    localparam int RIGHT_SPREAD = 23;
    localparam int BASE_RATE   = 44100;
    localparam int IN_GAIN     = 13107;
    localparam int ONE_Q16     = 65536;

    localparam int DEF_FS_HZ          = 48000;
    localparam int DEF_PREDELAY_DEPTH = 16384;
    localparam int DEF_COMB_DEPTH     = 2048;
    localparam int DEF_ALLPASS_DEPTH  = 1024;

    localparam int COMB_TUNE [0:NCOMB-1] = '{1116, 1188, 1277, 1356};
    localparam int AP_TUNE   [0:NAP-1]   = '{556, 441};

    localparam logic [15:0] RST_COMB_FEEDBACK = 16'd55050;
    localparam logic [14:0] RST_COMB_DAMP     = 15'd13107;
    localparam logic [13:0] RST_PREDELAY      = 14'd0;
    localparam logic [16:0] RST_WET_MIX       = 17'd19661;

    typedef enum logic [1:0] {
        CFG_COMB_FEEDBACK,
        CFG_COMB_DAMP,
        CFG_PREDELAY,
        CFG_WET_MIX
    } t_cfg_idx;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        t_sample left_in;
        t_sample right_in;
    } t_in_item;

    typedef struct packed {
        t_sample left_out;
        t_sample right_out;
    } t_out_item;

    typedef struct packed {
        logic [15:0] comb_feedback;
        logic [14:0] comb_damp;
        logic [13:0] predelay_samples;
        logic [16:0] wet_mix;
    } t_cfg;

    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_queue_head;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctl;

    // Saturate a wide signed value to the sample range.
    function automatic t_sample sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        logic signed [ACC_W-1:0] r;
        hi = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
        lo = -hi - ACC_W'(1);
        if (v > hi) begin
            r = hi;
        end else if (v < lo) begin
            r = lo;
        end else begin
            r = v;
        end
        return r[SAMPLE_BITS-1:0];
    endfunction

    // Round to nearest, halves towards plus infinity, then drop 16 bits.
    function automatic logic signed [ACC_W-1:0] rnd16(input logic signed [ACC_W-1:0] v);
        return (v + ACC_W'(32768)) >>> 16;
    endfunction

    // The same with a single bit dropped.
    function automatic logic signed [ACC_W-1:0] rnd1(input logic signed [ACC_W-1:0] v);
        return (v + ACC_W'(1)) >>> 1;
    endfunction

    function automatic int clamp_len(input int n, input int depth);
        if (n < 1) begin
            return 1;
        end else if (n > depth) begin
            return depth;
        end
        return n;
    endfunction

endpackage

[hw/rtl/scar_ram.sv]
// ============================================================================
// scar_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
module scar_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/scar_front.sv]
// ============================================================================
// scar_front: input side of the stereo reverb
// Holds the configuration registers and a two-entry queue of items waiting
// for the processing sequencer.
// ============================================================================
module scar_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  scar_pkg::t_in_item            i_in_data,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [scar_pkg::CFG_W-1:0]    i_cfg_data,
    input  scar_pkg::t_back_ctl           i_back,
    output scar_pkg::t_queue_head         o_head,
    output scar_pkg::t_cfg                o_cfg
);

    scar_pkg::t_in_item r_q [0:1];
    logic               r_rd_ptr;
    logic               r_wr_ptr;
    logic [1:0]         r_count;
    scar_pkg::t_cfg     r_cfg;
    logic               push;
    logic               pop;

    assign o_in_stall = (r_count == 2'd2) || i_back.clearing;
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_back.pop && (r_count != 2'd0);

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_q[r_rd_ptr];
    assign o_cfg        = r_cfg;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= i_in_data;
        end
        if (!i_rst_n) begin
            r_rd_ptr <= 1'b0;
            r_wr_ptr <= 1'b0;
            r_count  <= 2'd0;
            r_cfg.comb_feedback    <= scar_pkg::RST_COMB_FEEDBACK;
            r_cfg.comb_damp        <= scar_pkg::RST_COMB_DAMP;
            r_cfg.predelay_samples <= scar_pkg::RST_PREDELAY;
            r_cfg.wet_mix          <= scar_pkg::RST_WET_MIX;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
            if (i_cfg_we) begin
                unique case (scar_pkg::t_cfg_idx'(i_cfg_index))
                    scar_pkg::CFG_COMB_FEEDBACK: begin
                        r_cfg.comb_feedback <= i_cfg_data[15:0];
                    end
                    scar_pkg::CFG_COMB_DAMP: begin
                        r_cfg.comb_damp <= i_cfg_data[14:0];
                    end
                    scar_pkg::CFG_PREDELAY: begin
                        r_cfg.predelay_samples <= i_cfg_data[13:0];
                    end
                    scar_pkg::CFG_WET_MIX: begin
                        r_cfg.wet_mix <= i_cfg_data[16:0];
                    end
                endcase
            end
        end
    end

endmodule

[hw/rtl/scar_back.sv]
// ============================================================================
// scar_back: processing sequencer of the stereo reverb
// Steps one item through pre-delay, four combs, two allpasses and the mix,
// channel by channel, using one memory each for pre-delay, combs and allpasses.
// ============================================================================
module scar_back #(
    parameter int FS_HZ          = scar_pkg::DEF_FS_HZ,
    parameter int PREDELAY_DEPTH = scar_pkg::DEF_PREDELAY_DEPTH,
    parameter int COMB_DEPTH     = scar_pkg::DEF_COMB_DEPTH,
    parameter int ALLPASS_DEPTH  = scar_pkg::DEF_ALLPASS_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  scar_pkg::t_queue_head  i_head,
    input  scar_pkg::t_cfg         i_cfg,
    output scar_pkg::t_back_ctl    o_ctl,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output scar_pkg::t_out_item    o_out_data
);

    localparam int SB  = scar_pkg::SAMPLE_BITS;
    localparam int AW  = scar_pkg::ACC_W;
    localparam int PW  = $clog2(PREDELAY_DEPTH);
    localparam int CW  = $clog2(COMB_DEPTH);
    localparam int APW = $clog2(ALLPASS_DEPTH);
    localparam int CD  = 2 * scar_pkg::NCOMB * COMB_DEPTH;
    localparam int AD  = 2 * scar_pkg::NAP * ALLPASS_DEPTH;
    localparam int CAW = $clog2(CD);
    localparam int AAW = $clog2(AD);
    localparam int CLR_A = (PREDELAY_DEPTH > CD) ? PREDELAY_DEPTH : CD;
    localparam int CLR_N = (CLR_A > AD) ? CLR_A : AD;
    localparam int CLRW  = $clog2(CLR_N);

    localparam int COMB_LEN [0:7] = '{
        scar_pkg::clamp_len((scar_pkg::COMB_TUNE[0] * FS_HZ) / scar_pkg::BASE_RATE,
                            COMB_DEPTH),
        scar_pkg::clamp_len((scar_pkg::COMB_TUNE[1] * FS_HZ) / scar_pkg::BASE_RATE,
                            COMB_DEPTH),
        scar_pkg::clamp_len((scar_pkg::COMB_TUNE[2] * FS_HZ) / scar_pkg::BASE_RATE,
                            COMB_DEPTH),
        scar_pkg::clamp_len((scar_pkg::COMB_TUNE[3] * FS_HZ) / scar_pkg::BASE_RATE,
                            COMB_DEPTH),
        scar_pkg::clamp_len(((scar_pkg::COMB_TUNE[0] + scar_pkg::RIGHT_SPREAD) * FS_HZ)
                            / scar_pkg::BASE_RATE, COMB_DEPTH),
        scar_pkg::clamp_len(((scar_pkg::COMB_TUNE[1] + scar_pkg::RIGHT_SPREAD) * FS_HZ)
                            / scar_pkg::BASE_RATE, COMB_DEPTH),
        scar_pkg::clamp_len(((scar_pkg::COMB_TUNE[2] + scar_pkg::RIGHT_SPREAD) * FS_HZ)
                            / scar_pkg::BASE_RATE, COMB_DEPTH),
        scar_pkg::clamp_len(((scar_pkg::COMB_TUNE[3] + scar_pkg::RIGHT_SPREAD) * FS_HZ)
                            / scar_pkg::BASE_RATE, COMB_DEPTH)
    };

    localparam int AP_LEN [0:3] = '{
        scar_pkg::clamp_len((scar_pkg::AP_TUNE[0] * FS_HZ) / scar_pkg::BASE_RATE,
                            ALLPASS_DEPTH),
        scar_pkg::clamp_len((scar_pkg::AP_TUNE[1] * FS_HZ) / scar_pkg::BASE_RATE,
                            ALLPASS_DEPTH),
        scar_pkg::clamp_len(((scar_pkg::AP_TUNE[0] + scar_pkg::RIGHT_SPREAD) * FS_HZ)
                            / scar_pkg::BASE_RATE, ALLPASS_DEPTH),
        scar_pkg::clamp_len(((scar_pkg::AP_TUNE[1] + scar_pkg::RIGHT_SPREAD) * FS_HZ)
                            / scar_pkg::BASE_RATE, ALLPASS_DEPTH)
    };

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_PD,
        S_X,
        S_C_RD,
        S_C_M1,
        S_C_M2,
        S_C_M3,
        S_A_RD,
        S_A_OP,
        S_MIX1,
        S_MIX2,
        S_DONE
    } t_state;

    t_state                    r_state;
    logic [CLRW-1:0]           r_clr;
    logic                      r_ch;
    logic [1:0]                r_k;
    scar_pkg::t_in_item        r_item;
    scar_pkg::t_sample         r_x;
    scar_pkg::t_sample         r_lp;
    scar_pkg::t_sample         r_res_l;
    scar_pkg::t_sample         r_res_r;
    logic signed [AW-1:0]      r_sum;
    logic signed [AW-1:0]      r_prod;
    logic [PW-1:0]             r_pd_ptr;
    logic [CW-1:0]             r_cptr [0:7];
    scar_pkg::t_sample         r_lpm  [0:7];
    logic [APW-1:0]            r_aptr [0:3];
    logic                      r_out_valid;
    scar_pkg::t_out_item       r_out_data;

    // Memory ports
    logic                      pd_we;
    logic [PW-1:0]             pd_waddr;
    logic [PW-1:0]             pd_raddr;
    logic [2*SB-1:0]           pd_wdata;
    logic [2*SB-1:0]           pd_rdata;
    logic                      cm_we;
    logic [CAW-1:0]            cm_waddr;
    logic [CAW-1:0]            cm_raddr;
    scar_pkg::t_sample         cm_wdata;
    scar_pkg::t_sample         cm_rdata;
    logic                      ap_we;
    logic [AAW-1:0]            ap_waddr;
    logic [AAW-1:0]            ap_raddr;
    scar_pkg::t_sample         ap_wdata;
    scar_pkg::t_sample         ap_rdata;

    // Working values
    logic [2:0]                cli;
    logic [1:0]                ali;
    logic [CAW-1:0]            comb_addr;
    logic [AAW-1:0]            ap_addr;
    logic [31:0]               pd_d;
    logic [31:0]               pd_w;
    logic [31:0]               pd_r;
    scar_pkg::t_sample         dry;
    scar_pkg::t_sample         pd_val;
    logic signed [AW-1:0]      damp_s;
    logic signed [AW-1:0]      onemd_s;
    logic signed [AW-1:0]      fb_s;
    logic signed [AW-1:0]      mix_s;
    logic signed [AW-1:0]      onemm_s;
    logic [CW-1:0]             cptr_next;
    logic [APW-1:0]            aptr_next;
    logic                      out_free;

    assign cli = {r_ch, r_k};
    assign ali = {r_ch, r_k[0]};
    assign comb_addr = CAW'(cli) * CAW'(COMB_DEPTH) + CAW'(r_cptr[cli]);
    assign ap_addr   = AAW'(ali) * AAW'(ALLPASS_DEPTH) + AAW'(r_aptr[ali]);

    always_comb begin
        if (32'(i_cfg.predelay_samples) >= 32'(PREDELAY_DEPTH)) begin
            pd_d = 32'(PREDELAY_DEPTH - 1);
        end else begin
            pd_d = 32'(i_cfg.predelay_samples);
        end
        pd_w = 32'(r_pd_ptr);
        if (pd_w >= pd_d) begin
            pd_r = pd_w - pd_d;
        end else begin
            pd_r = pd_w + 32'(PREDELAY_DEPTH) - pd_d;
        end
    end

    assign dry = r_ch ? r_item.right_in : r_item.left_in;

    // With no pre-delay the sample just written is used directly.
    always_comb begin
        if (pd_d == 32'd0) begin
            pd_val = dry;
        end else if (r_ch) begin
            pd_val = pd_rdata[2*SB-1:SB];
        end else begin
            pd_val = pd_rdata[SB-1:0];
        end
    end

    always_comb begin
        damp_s  = AW'(i_cfg.comb_damp);
        onemd_s = AW'(scar_pkg::ONE_Q16) - damp_s;
        fb_s    = AW'(i_cfg.comb_feedback);
        if (i_cfg.wet_mix > 17'(scar_pkg::ONE_Q16)) begin
            mix_s = AW'(scar_pkg::ONE_Q16);
        end else begin
            mix_s = AW'(i_cfg.wet_mix);
        end
        onemm_s = AW'(scar_pkg::ONE_Q16) - mix_s;
    end

    always_comb begin
        if (32'(r_cptr[cli]) + 32'd1 >= 32'(COMB_LEN[cli])) begin
            cptr_next = '0;
        end else begin
            cptr_next = r_cptr[cli] + CW'(1);
        end
        if (32'(r_aptr[ali]) + 32'd1 >= 32'(AP_LEN[ali])) begin
            aptr_next = '0;
        end else begin
            aptr_next = r_aptr[ali] + APW'(1);
        end
    end

    // Memory control follows the sequencer state.
    always_comb begin
        pd_we    = 1'b0;
        pd_waddr = r_pd_ptr;
        pd_raddr = PW'(pd_r);
        pd_wdata = {r_item.right_in, r_item.left_in};
        cm_we    = 1'b0;
        cm_waddr = comb_addr;
        cm_raddr = comb_addr;
        cm_wdata = scar_pkg::sat(AW'(r_x) + scar_pkg::rnd16(AW'(r_lp) * fb_s));
        ap_we    = 1'b0;
        ap_waddr = ap_addr;
        ap_raddr = ap_addr;
        ap_wdata = scar_pkg::sat(r_sum + scar_pkg::rnd1(AW'(ap_rdata)));
        unique case (r_state)
            S_CLR: begin
                pd_we    = (32'(r_clr) < 32'(PREDELAY_DEPTH));
                pd_waddr = PW'(r_clr);
                pd_wdata = '0;
                cm_we    = (32'(r_clr) < 32'(CD));
                cm_waddr = CAW'(r_clr);
                cm_wdata = '0;
                ap_we    = (32'(r_clr) < 32'(AD));
                ap_waddr = AAW'(r_clr);
                ap_wdata = '0;
            end
            S_PD: begin
                pd_we = 1'b1;
            end
            S_C_M3: begin
                cm_we = 1'b1;
            end
            S_A_OP: begin
                ap_we = 1'b1;
            end
            S_IDLE, S_X, S_C_RD, S_C_M1, S_C_M2, S_A_RD, S_MIX1, S_MIX2, S_DONE: begin
            end
        endcase
    end

    assign o_ctl.pop      = (r_state == S_IDLE) && i_head.valid;
    assign o_ctl.clearing = (r_state == S_CLR);
    assign out_free       = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_ch        <= 1'b0;
            r_k         <= '0;
            r_pd_ptr    <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_cptr[i] <= '0;
                r_lpm[i]  <= '0;
            end
            for (int i = 0; i < 4; i++) begin
                r_aptr[i] <= '0;
            end
        end else begin
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + CLRW'(1);
                    if (32'(r_clr) == 32'(CLR_N - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_item  <= i_head.item;
                        r_ch    <= 1'b0;
                        r_state <= S_PD;
                    end
                end
                S_PD: begin
                    r_state <= S_X;
                end
                S_X: begin
                    r_x     <= scar_pkg::sat(scar_pkg::rnd16(AW'(pd_val)
                                                             * AW'(scar_pkg::IN_GAIN)));
                    r_sum   <= '0;
                    r_k     <= '0;
                    r_state <= S_C_RD;
                end
                S_C_RD: begin
                    r_state <= S_C_M1;
                end
                S_C_M1: begin
                    r_prod  <= AW'(cm_rdata) * onemd_s;
                    r_sum   <= r_sum + AW'(cm_rdata);
                    r_state <= S_C_M2;
                end
                S_C_M2: begin
                    r_lp       <= scar_pkg::sat(scar_pkg::rnd16(r_prod
                                                              + AW'(r_lpm[cli]) * damp_s));
                    r_lpm[cli] <= scar_pkg::sat(scar_pkg::rnd16(r_prod
                                                              + AW'(r_lpm[cli]) * damp_s));
                    r_state    <= S_C_M3;
                end
                S_C_M3: begin
                    r_cptr[cli] <= cptr_next;
                    if (r_k == 2'd3) begin
                        r_sum   <= AW'(scar_pkg::sat(r_sum));
                        r_k     <= '0;
                        r_state <= S_A_RD;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_C_RD;
                    end
                end
                S_A_RD: begin
                    r_state <= S_A_OP;
                end
                S_A_OP: begin
                    r_sum       <= AW'(scar_pkg::sat(AW'(ap_rdata) - r_sum));
                    r_aptr[ali] <= aptr_next;
                    if (r_k[0]) begin
                        r_k     <= '0;
                        r_state <= S_MIX1;
                    end else begin
                        r_k     <= 2'd1;
                        r_state <= S_A_RD;
                    end
                end
                S_MIX1: begin
                    r_prod  <= r_sum * mix_s;
                    r_state <= S_MIX2;
                end
                S_MIX2: begin
                    if (r_ch) begin
                        r_res_r <= scar_pkg::sat(scar_pkg::rnd16(r_prod + AW'(dry) * onemm_s));
                        r_state <= S_DONE;
                    end else begin
                        r_res_l <= scar_pkg::sat(scar_pkg::rnd16(r_prod + AW'(dry) * onemm_s));
                        r_ch    <= 1'b1;
                        r_state <= S_X;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_data.left_out  <= r_res_l;
                        r_out_data.right_out <= r_res_r;
                        if (32'(r_pd_ptr) + 32'd1 >= 32'(PREDELAY_DEPTH)) begin
                            r_pd_ptr <= '0;
                        end else begin
                            r_pd_ptr <= r_pd_ptr + PW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    scar_ram #(.WIDTH(2 * SB), .DEPTH(PREDELAY_DEPTH)) u_pd_ram (
        .i_clk   (i_clk),
        .i_we    (pd_we),
        .i_waddr (pd_waddr),
        .i_wdata (pd_wdata),
        .i_raddr (pd_raddr),
        .o_rdata (pd_rdata)
    );

    scar_ram #(.WIDTH(SB), .DEPTH(CD)) u_comb_ram (
        .i_clk   (i_clk),
        .i_we    (cm_we),
        .i_waddr (cm_waddr),
        .i_wdata (cm_wdata),
        .i_raddr (cm_raddr),
        .o_rdata (cm_rdata)
    );

    scar_ram #(.WIDTH(SB), .DEPTH(AD)) u_ap_ram (
        .i_clk   (i_clk),
        .i_we    (ap_we),
        .i_waddr (ap_waddr),
        .i_wdata (ap_wdata),
        .i_raddr (ap_raddr),
        .o_rdata (ap_rdata)
    );

endmodule

[hw/rtl/stereo_comb_allpass_reverb.sv]
// ============================================================================
// stereo_comb_allpass_reverb: stereo comb and allpass reverb
// Four damped feedback combs and two allpasses per channel, with pre-delay
// and a wet/dry mix, on Q1.23 samples.
// ============================================================================
// Usage. Each input item is one stereo sample pair, taken on the input
// channel when i_in_valid is high and o_in_stall is low. Each item yields
// exactly one output item, a mixed and saturated stereo pair, offered on
// o_out_valid with o_out_data until the receiver takes it with i_out_stall low.
// In the sequencer an item passes through these steps: one to pick it from the
// queue, one for the pre-delay memory access, for each channel an input gain
// step, four combs of four steps, two allpasses of two steps and two mixing
// steps, and one to hand the result to the output register. The single
// sequencer works on one item at a time, using the one read port of each
// delay memory, and takes no new item until it has handed on the last; a
// two-entry queue in front takes items while the sequencer works.
// After reset the block clears every delay memory, one address a cycle, over
// max(PREDELAY_DEPTH, 8*COMB_DEPTH, 4*ALLPASS_DEPTH) addresses (16384 by
// default), and stalls the input meanwhile; configuration writes are taken at
// any time and return the registers to their defaults on reset. When the
// receiver stalls, the finished item waits in the output register and the
// sequencer holds in its final step once the next item is also done.
// ============================================================================
module stereo_comb_allpass_reverb #(
    parameter int FS_HZ          = scar_pkg::DEF_FS_HZ,
    parameter int PREDELAY_DEPTH = scar_pkg::DEF_PREDELAY_DEPTH,
    parameter int COMB_DEPTH     = scar_pkg::DEF_COMB_DEPTH,
    parameter int ALLPASS_DEPTH  = scar_pkg::DEF_ALLPASS_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  scar_pkg::t_in_item         i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output scar_pkg::t_out_item        o_out_data,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [scar_pkg::CFG_W-1:0] i_cfg_data
);

    // Queue head and configuration pass from the front to the sequencer;
    // the sequencer answers with its pop and clearing status.
    scar_pkg::t_queue_head head;
    scar_pkg::t_cfg        cfg;
    scar_pkg::t_back_ctl   back_ctl;

    scar_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_back      (back_ctl),
        .o_head      (head),
        .o_cfg       (cfg)
    );

    scar_back #(
        .FS_HZ          (FS_HZ),
        .PREDELAY_DEPTH (PREDELAY_DEPTH),
        .COMB_DEPTH     (COMB_DEPTH),
        .ALLPASS_DEPTH  (ALLPASS_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_cfg       (cfg),
        .o_ctl       (back_ctl),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

[verif/stereo_comb_allpass_reverb_tb.sv]
// ============================================================================
// stereo_comb_allpass_reverb_tb: self-checking bench for the stereo reverb
// Drives stereo pairs in bursts, stalls the output on its own pattern and
// checks every output pair against a behavioural model of the combs,
// allpasses, pre-delay and wet/dry mix kept inside the bench.
// ============================================================================
`timescale 1ns / 1ps

module stereo_comb_allpass_reverb_tb;

    localparam int PD_DEPTH   = scar_pkg::DEF_PREDELAY_DEPTH;
    localparam int CB_DEPTH   = scar_pkg::DEF_COMB_DEPTH;
    localparam int AP_DEPTH   = scar_pkg::DEF_ALLPASS_DEPTH;
    localparam int IDLE_LIMIT = 60000;
    localparam int N_RANDOM   = 1930;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    scar_pkg::t_in_item   i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    scar_pkg::t_out_item  o_out_data;
    logic                 i_cfg_we;
    logic [1:0]           i_cfg_index;
    logic [scar_pkg::CFG_W-1:0] i_cfg_data;

    stereo_comb_allpass_reverb u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // The clock runs freely with a 10 ns period.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Behavioural model of the reverb. It mirrors every delay memory and
    // pointer, and the four configuration registers.
    // ------------------------------------------------------------------
    logic [15:0] mdl_feedback;
    logic [14:0] mdl_damp;
    logic [13:0] mdl_predelay;
    logic [16:0] mdl_wet;

    longint mdl_pd_mem [2][PD_DEPTH];
    int     mdl_pd_ptr;
    longint mdl_comb_mem [8][CB_DEPTH];
    int     mdl_comb_ptr [8];
    longint mdl_comb_lp  [8];
    longint mdl_ap_mem [4][AP_DEPTH];
    int     mdl_ap_ptr [4];

    scar_pkg::t_out_item pending_pairs [$];
    scar_pkg::t_in_item  stim_pairs [$];
    int                  fail_count;

    function automatic longint clip(input longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    // Round to nearest, halves towards plus infinity, then shift right.
    function automatic longint round_down(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic int tap_len(input int tune, input int depth);
        longint n;
        n = longint'(tune) * scar_pkg::DEF_FS_HZ / scar_pkg::BASE_RATE;
        if (n < 1) n = 1;
        if (n > depth) n = depth;
        return int'(n);
    endfunction

    task automatic model_clear();
        foreach (mdl_pd_mem[c, a]) mdl_pd_mem[c][a] = 0;
        foreach (mdl_comb_mem[c, a]) mdl_comb_mem[c][a] = 0;
        foreach (mdl_ap_mem[c, a]) mdl_ap_mem[c][a] = 0;
        foreach (mdl_comb_ptr[c]) begin
            mdl_comb_ptr[c] = 0;
            mdl_comb_lp[c] = 0;
        end
        foreach (mdl_ap_ptr[c]) mdl_ap_ptr[c] = 0;
        mdl_pd_ptr   = 0;
        mdl_feedback = scar_pkg::RST_COMB_FEEDBACK;
        mdl_damp     = scar_pkg::RST_COMB_DAMP;
        mdl_predelay = scar_pkg::RST_PREDELAY;
        mdl_wet      = scar_pkg::RST_WET_MIX;
    endtask

    // One channel of the reverb: pre-delay, four combs, two allpasses, mix.
    function automatic longint reverb_channel(input int ch, input longint dry);
        int     d, rd, li, len, p;
        longint x, sum, o, lp, b, m;
        d = (mdl_predelay >= PD_DEPTH) ? PD_DEPTH - 1 : int'(mdl_predelay);
        rd = (mdl_pd_ptr >= d) ? mdl_pd_ptr - d : mdl_pd_ptr + PD_DEPTH - d;
        mdl_pd_mem[ch][mdl_pd_ptr] = dry;
        x = clip(round_down(mdl_pd_mem[ch][rd] * scar_pkg::IN_GAIN, 16));
        sum = 0;
        for (int k = 0; k < scar_pkg::NCOMB; k++) begin
            li = ch * scar_pkg::NCOMB + k;
            len = tap_len(scar_pkg::COMB_TUNE[k] + (ch ? scar_pkg::RIGHT_SPREAD : 0),
                          CB_DEPTH);
            p = mdl_comb_ptr[li];
            if (p >= len) p = 0;
            o = mdl_comb_mem[li][p];
            lp = clip(round_down(o * (scar_pkg::ONE_Q16 - longint'(mdl_damp))
                      + mdl_comb_lp[li] * longint'(mdl_damp), 16));
            mdl_comb_lp[li] = lp;
            mdl_comb_mem[li][p] = clip(x + round_down(lp * longint'(mdl_feedback), 16));
            p++;
            if (p >= len) p = 0;
            mdl_comb_ptr[li] = p;
            sum += o;
        end
        sum = clip(sum);
        for (int k = 0; k < scar_pkg::NAP; k++) begin
            li = ch * scar_pkg::NAP + k;
            len = tap_len(scar_pkg::AP_TUNE[k] + (ch ? scar_pkg::RIGHT_SPREAD : 0),
                          AP_DEPTH);
            p = mdl_ap_ptr[li];
            if (p >= len) p = 0;
            b = mdl_ap_mem[li][p];
            mdl_ap_mem[li][p] = clip(sum + round_down(b, 1));
            sum = clip(b - sum);
            p++;
            if (p >= len) p = 0;
            mdl_ap_ptr[li] = p;
        end
        m = (mdl_wet > scar_pkg::ONE_Q16) ? scar_pkg::ONE_Q16 : longint'(mdl_wet);
        return clip(round_down(sum * m + dry * (scar_pkg::ONE_Q16 - m), 16));
    endfunction

    function automatic scar_pkg::t_out_item reverb_pair(input scar_pkg::t_in_item pair);
        scar_pkg::t_out_item r;
        r.left_out  = scar_pkg::t_sample'(reverb_channel(0, longint'(pair.left_in)));
        r.right_out = scar_pkg::t_sample'(reverb_channel(1, longint'(pair.right_in)));
        mdl_pd_ptr  = (mdl_pd_ptr + 1) % PD_DEPTH;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: takes pairs from the stimulus queue in bursts of random
    // length. A pause request holds it off until every result is back.
    // ------------------------------------------------------------------
    int  burst_left;
    int  gap_left;
    bit  hold_sender;
    int  accepted_count;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            // Compute whether the current item leaves this edge.
            automatic bit taken = i_in_valid && !o_in_stall;
            automatic bit busy  = i_in_valid && !taken;
            if (taken) begin
                void'(stim_pairs.pop_front());
                pending_pairs.push_back(reverb_pair(i_in_data));
                accepted_count <= accepted_count + 1;
            end
            if (busy) begin
                // A stalled item stays put.
            end else if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (stim_pairs.size() > 0 && !hold_sender) begin
                i_in_valid <= 1'b1;
                i_in_data  <= stim_pairs[0];
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(40, 1);
                    gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(60, 1);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver and checker. The stall pattern changes mode now and then;
    // a long hold-off can be requested to fill the block.
    // ------------------------------------------------------------------
    int stall_mode;
    int hold_off_left;
    bit want_hold_off;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall   <= 1'b0;
            stall_mode    <= 0;
            hold_off_left <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_pairs.size() == 0) begin
                    $display("%0t: unexpected output pair, expected none, actual %h",
                             $time, o_out_data);
                    fail_count++;
                end else begin
                    automatic scar_pkg::t_out_item want = pending_pairs.pop_front();
                    if (o_out_data.left_out !== want.left_out) begin
                        $display("%0t: left_out expected %0d actual %0d", $time,
                                 want.left_out, o_out_data.left_out);
                        fail_count++;
                    end
                    if (o_out_data.right_out !== want.right_out) begin
                        $display("%0t: right_out expected %0d actual %0d", $time,
                                 want.right_out, o_out_data.right_out);
                        fail_count++;
                    end
                end
            end
            if (want_hold_off && hold_off_left == 0) begin
                hold_off_left <= 2000;
                want_hold_off <= 1'b0;
                i_out_stall   <= 1'b1;
            end else if (hold_off_left > 0) begin
                hold_off_left <= hold_off_left - 1;
                i_out_stall   <= (hold_off_left > 1);
            end else begin
                if ($urandom_range(199, 0) == 0) stall_mode <= $urandom_range(3, 0);
                case (stall_mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(3, 0) == 0);
                    2: i_out_stall <= ($urandom_range(1, 0) == 0);
                    default: i_out_stall <= ($urandom_range(9, 0) != 0);
                endcase
            end
        end
    end

    // Watchdog: counts cycles in which nothing is accepted on either side.
    int idle_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic scar_pkg::t_sample rand_sample();
        case ($urandom_range(5, 0))
            0: return scar_pkg::t_sample'(24'h7FFFFF);
            1: return scar_pkg::t_sample'(24'h800000);
            2: return scar_pkg::t_sample'($urandom_range(2000, 0))
                      - scar_pkg::t_sample'(1000);
            default: return scar_pkg::t_sample'($urandom);
        endcase
    endfunction

    // Waits until every queued pair has gone in and every result is back,
    // then for the block's latency so that it is idle.
    task automatic drain();
        wait (stim_pairs.size() == 0 && !i_in_valid && pending_pairs.size() == 0);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_reg(input scar_pkg::t_cfg_idx idx,
                             input logic [scar_pkg::CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        // The register is taken at the edge just passed; the model follows.
        case (idx)
            scar_pkg::CFG_COMB_FEEDBACK: mdl_feedback = value[15:0];
            scar_pkg::CFG_COMB_DAMP:     mdl_damp     = value[14:0];
            scar_pkg::CFG_PREDELAY:      mdl_predelay = value[13:0];
            default:                     mdl_wet      = value[16:0];
        endcase
    endtask

    task automatic add_pair(input scar_pkg::t_sample l, input scar_pkg::t_sample r);
        scar_pkg::t_in_item it;
        it.left_in  = l;
        it.right_in = r;
        stim_pairs.push_back(it);
    endtask

    // Queues n random pairs, some as quiet tails so the reverb rings out.
    task automatic add_random(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9, 0) < 2) add_pair('0, '0);
            else add_pair(rand_sample(), rand_sample());
        end
    endtask

    initial begin
        int mark;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_stall   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = scar_pkg::CFG_COMB_FEEDBACK;
        i_cfg_data    = '0;
        hold_sender   = 1'b0;
        want_hold_off = 1'b0;
        fail_count    = 0;
        accepted_count = 0;
        model_clear();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pairs at the default settings: extremes and an impulse.
        add_pair(scar_pkg::t_sample'(24'h7FFFFF), scar_pkg::t_sample'(24'h800000));
        add_pair(scar_pkg::t_sample'(24'h800000), scar_pkg::t_sample'(24'h7FFFFF));
        add_pair(scar_pkg::t_sample'(24'h7FFFFF), scar_pkg::t_sample'(24'h7FFFFF));
        add_pair(scar_pkg::t_sample'(24'h800000), scar_pkg::t_sample'(24'h800000));
        add_pair(scar_pkg::t_sample'(1), scar_pkg::t_sample'(-1));
        add_pair('0, '0);
        add_pair(scar_pkg::t_sample'(24'h555555), scar_pkg::t_sample'(24'hAAAAAA));
        add_pair(scar_pkg::t_sample'(24'hAAAAAA), scar_pkg::t_sample'(24'h555555));
        drain();

        // All wet, feedback just under one, no damping: internal saturation on full scale.
        write_reg(scar_pkg::CFG_WET_MIX, 17'd65536);
        write_reg(scar_pkg::CFG_COMB_FEEDBACK, 17'd64225);
        write_reg(scar_pkg::CFG_COMB_DAMP, 17'd0);
        for (int i = 0; i < 8; i++) begin
            add_pair(scar_pkg::t_sample'(24'h7FFFFF), scar_pkg::t_sample'(24'h800000));
        end
        // A wet mix above one is clamped to all wet.
        drain();
        write_reg(scar_pkg::CFG_WET_MIX, 17'h1FFFF);
        add_random(6);
        drain();

        // Pre-delay of the largest value, then random content over a phase
        // where the long hold-off fills the block.
        write_reg(scar_pkg::CFG_PREDELAY, 17'h3FFF);
        write_reg(scar_pkg::CFG_COMB_DAMP, 17'h7FFF);
        write_reg(scar_pkg::CFG_COMB_FEEDBACK, 17'hFFFF);
        write_reg(scar_pkg::CFG_WET_MIX, 17'd0);
        want_hold_off = 1'b1;
        add_random(N_RANDOM / 5);
        drain();

        // The sender pauses until all results are back, mid-stream.
        write_reg(scar_pkg::CFG_PREDELAY, 17'd0);
        write_reg(scar_pkg::CFG_COMB_FEEDBACK, 17'd45875);
        write_reg(scar_pkg::CFG_COMB_DAMP, 17'd26214);
        write_reg(scar_pkg::CFG_WET_MIX, 17'd32768);
        mark = accepted_count;
        add_random(N_RANDOM / 5);
        wait (accepted_count >= mark + N_RANDOM / 10);
        @(posedge i_clk);
        hold_sender = 1'b1;
        wait (pending_pairs.size() == 0 && !i_in_valid);
        hold_sender = 1'b0;
        drain();

        // Random settings for the rest, a phase at a time.
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(scar_pkg::CFG_COMB_FEEDBACK, scar_pkg::CFG_W'($urandom));
            write_reg(scar_pkg::CFG_COMB_DAMP, scar_pkg::CFG_W'($urandom));
            write_reg(scar_pkg::CFG_PREDELAY, ($urandom_range(1, 0) == 0)
                      ? scar_pkg::CFG_W'($urandom_range(3000, 0))
                      : scar_pkg::CFG_W'($urandom));
            write_reg(scar_pkg::CFG_WET_MIX, scar_pkg::CFG_W'($urandom));
            add_random(N_RANDOM / 10);
            drain();
        end

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
